FILE: rtl/sll_pkg.sv
// Shared types, token codes and character class helpers for the lexer.
// No dependencies; the lexer core, scanner and queue import this package.
package sll_pkg;

  // Default parameter values for the top level
  localparam int POSITION_BITS_DEF  = 16;
  localparam int KEYWORD_PREFIX_DEF = 4;

  // Output field widths, fixed by the token format
  localparam int TYPE_W = 5;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 16;

  // Result queue depth (power of two, at least 2)
  localparam int OUTQ_DEPTH = 4;

  // Token type codes
  localparam logic [TYPE_W-1:0] T_EOF    = 5'd0;
  localparam logic [TYPE_W-1:0] T_INT    = 5'd1;
  localparam logic [TYPE_W-1:0] T_EXIT   = 5'd2;
  localparam logic [TYPE_W-1:0] T_IF     = 5'd3;
  localparam logic [TYPE_W-1:0] T_ELSE   = 5'd4;
  localparam logic [TYPE_W-1:0] T_IDENT  = 5'd5;
  localparam logic [TYPE_W-1:0] T_EE     = 5'd6;
  localparam logic [TYPE_W-1:0] T_ASSIGN = 5'd7;
  localparam logic [TYPE_W-1:0] T_LTE    = 5'd8;
  localparam logic [TYPE_W-1:0] T_LT     = 5'd9;
  localparam logic [TYPE_W-1:0] T_GTE    = 5'd10;
  localparam logic [TYPE_W-1:0] T_GT     = 5'd11;
  localparam logic [TYPE_W-1:0] T_OR     = 5'd12;
  localparam logic [TYPE_W-1:0] T_AND    = 5'd13;
  localparam logic [TYPE_W-1:0] T_PLUS   = 5'd14;
  localparam logic [TYPE_W-1:0] T_MINUS  = 5'd15;
  localparam logic [TYPE_W-1:0] T_STAR   = 5'd16;
  localparam logic [TYPE_W-1:0] T_SLASH  = 5'd17;
  localparam logic [TYPE_W-1:0] T_LPAREN = 5'd18;
  localparam logic [TYPE_W-1:0] T_RPAREN = 5'd19;
  localparam logic [TYPE_W-1:0] T_LBRACE = 5'd20;
  localparam logic [TYPE_W-1:0] T_RBRACE = 5'd21;
  localparam logic [TYPE_W-1:0] T_CARET  = 5'd22;
  localparam logic [TYPE_W-1:0] T_SEMI   = 5'd23;
  localparam logic [TYPE_W-1:0] T_ERROR  = 5'd24;

  // Input op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Keyword spellings
  localparam logic [31:0] KW_EXIT = "exit";
  localparam logic [23:0] KW_INT  = "int";
  localparam logic [15:0] KW_IF   = "if";
  localparam logic [31:0] KW_ELSE = "else";

  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = " ";
  localparam logic [7:0] CH_NUL        = 8'h00;

  // One result as it sits in the queue and leaves the block
  typedef struct packed {
    logic [TYPE_W-1:0] token_type;
    logic [POS_W-1:0]  token_start;
    logic [LEN_W-1:0]  token_length;
    logic              last_of_item;
  } sll_token_t;

  // Up to two results written by one accepted item
  typedef struct packed {
    logic       valid0;
    logic       valid1;
    sll_token_t tok0;
    sll_token_t tok1;
  } sll_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

  // First byte of a possible two-character operator
  function automatic logic is_pend_start(input logic [7:0] c);
    return (c == "=") || (c == "<") || (c == ">") || (c == "|") || (c == "&");
  endfunction

  // Single-character operator code; T_EOF means none
  function automatic logic [TYPE_W-1:0] single_op(input logic [7:0] c);
    logic [TYPE_W-1:0] t;
    unique case (c)
      "+":     t = T_PLUS;
      "-":     t = T_MINUS;
      "*":     t = T_STAR;
      "/":     t = T_SLASH;
      "(":     t = T_LPAREN;
      ")":     t = T_RPAREN;
      "{":     t = T_LBRACE;
      "}":     t = T_RBRACE;
      "^":     t = T_CARET;
      ";":     t = T_SEMI;
      default: t = T_EOF;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/sll_in_if.sv
// Input channel of the lexer: one source byte or an end-of-text mark.
// Depends on nothing.
interface sll_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

FILE: rtl/sll_out_if.sv
// Output channel of the lexer: one token per transaction.
// Depends on nothing.
interface sll_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_type;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_item;

  modport source (output valid, output token_type, output token_start,
                  output token_length, output last_of_item, input ready);
  modport sink   (input valid, input token_type, input token_start,
                  input token_length, input last_of_item, output ready);
endinterface

FILE: rtl/small_language_lexer_core.sv
// Lexer top level: byte scanner followed by a four-entry token queue.
// Depends on sll_pkg, sll_in_if, sll_out_if, sll_scan and sll_outq.
//
// The lexer takes one source byte (or an end-of-text mark) per cycle and
// returns tokens with a type, a start position and a length. A byte is
// decided in the cycle it is accepted and its tokens appear at the output
// from the next cycle on. Most bytes produce zero or one token; a byte that
// closes a held token and also forms one of its own, and every end of text
// after a held token, produces two, which take two output transactions.
// Input ready depends only on queue occupancy: it is high while at least two
// of the four queue slots are free, so with an always-ready consumer the
// sustained rate is one byte per cycle, falling only over stretches where
// every byte yields two tokens. Space, tab and newline are skipped; after
// an unknown byte or a lone bar or ampersand an error token is sent and
// bytes are dropped until end of text, which resets positions to zero.
module small_language_lexer_core #(
  parameter int POSITION_BITS  = sll_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_PREFIX = sll_pkg::KEYWORD_PREFIX_DEF
) (
  input logic     clk,
  input logic     rst,
  sll_in_if.sink  item_in,
  sll_out_if.source token_out
);
  import sll_pkg::*;

  sll_push_t  push;
  sll_token_t head_tok;
  logic       room;
  logic       take;
  logic       out_valid;

  // Accept a byte whenever the queue can hold its results
  assign item_in.ready = room;
  assign take          = item_in.valid && room;

  sll_scan #(
    .POSITION_BITS  (POSITION_BITS),
    .KEYWORD_PREFIX (KEYWORD_PREFIX)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .op   (item_in.op),
    .ch   (item_in.ch),
    .push (push)
  );

  sll_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (token_out.ready),
    .out_valid (out_valid),
    .head_tok  (head_tok),
    .room      (room)
  );

  // Drive the output channel from the queue head
  assign token_out.valid        = out_valid;
  assign token_out.token_type   = head_tok.token_type;
  assign token_out.token_start  = head_tok.token_start;
  assign token_out.token_length = head_tok.token_length;
  assign token_out.last_of_item = head_tok.last_of_item;

endmodule

FILE: rtl/sll_scan.sv
// Scanner state and per-byte token decision for the lexer.
// Depends on sll_pkg; feeds sll_outq with up to two tokens per item.
module sll_scan #(
  parameter int POSITION_BITS  = sll_pkg::POSITION_BITS_DEF,
  parameter int KEYWORD_PREFIX = sll_pkg::KEYWORD_PREFIX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              op,
  input  logic [7:0]        ch,
  output sll_pkg::sll_push_t push
);
  import sll_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int LB = (PB < LEN_W) ? PB : LEN_W;

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_NUM   = 5'b00010,
    M_IDENT = 5'b00100,
    M_PEND  = 5'b01000,
    M_ERROR = 5'b10000
  } mode_t;

  mode_t         mode, mode_next;
  logic [7:0]    pend_ch, pend_ch_next;
  logic [7:0]    prefix [KEYWORD_PREFIX];
  logic [7:0]    prefix_next [KEYWORD_PREFIX];
  logic [PB-1:0] start_pos, start_pos_next;
  logic [LB-1:0] run_len, run_len_next;
  logic [PB-1:0] byte_pos, byte_pos_next;

  // Held token, as it would be flushed now
  logic              hold_v;
  logic              hold_err;
  logic [TYPE_W-1:0] hold_type;
  logic [LB-1:0]     hold_len;

  // First (flushed or pair) and second (new) result of this item
  logic              f_v, s_v;
  logic [TYPE_W-1:0] f_type, s_type;
  logic [PB-1:0]     f_start, s_start;
  logic [LB-1:0]     f_len, s_len;

  logic              is_end;
  logic              go_idle;
  logic [TYPE_W-1:0] pair_type;
  logic [TYPE_W-1:0] sop;
  logic [LB-1:0]     run_ext;

  // Classify the held token
  always_comb begin
    hold_v    = 1'b0;
    hold_err  = 1'b0;
    hold_type = T_IDENT;
    hold_len  = run_len;
    unique case (mode)
      M_NUM: begin
        hold_v    = 1'b1;
        hold_type = T_INT;
      end
      M_IDENT: begin
        hold_v = 1'b1;
        if (run_len == LB'(4) && {prefix[0], prefix[1], prefix[2], prefix[3]} == KW_EXIT)
          hold_type = T_EXIT;
        else if (run_len == LB'(3) && {prefix[0], prefix[1], prefix[2]} == KW_INT)
          hold_type = T_INT;
        else if (run_len == LB'(2) && {prefix[0], prefix[1]} == KW_IF)
          hold_type = T_IF;
        else if (run_len == LB'(4) && {prefix[0], prefix[1], prefix[2], prefix[3]} == KW_ELSE)
          hold_type = T_ELSE;
        else
          hold_type = T_IDENT;
      end
      M_PEND: begin
        hold_v   = 1'b1;
        hold_len = LB'(1);
        if (pend_ch == "|" || pend_ch == "&") begin
          hold_err  = 1'b1;
          hold_type = T_ERROR;
        end else if (pend_ch == "=") begin
          hold_type = T_ASSIGN;
        end else if (pend_ch == "<") begin
          hold_type = T_LT;
        end else begin
          hold_type = T_GT;
        end
      end
      M_IDLE, M_ERROR: hold_v = 1'b0;
      default: hold_v = 1'b0;
    endcase
  end

  // Match a two-character operator against the held byte
  always_comb begin
    pair_type = T_EOF;
    if (ch == "=" && pend_ch == "=")      pair_type = T_EE;
    else if (ch == "=" && pend_ch == "<") pair_type = T_LTE;
    else if (ch == "=" && pend_ch == ">") pair_type = T_GTE;
    else if (ch == "|" && pend_ch == "|") pair_type = T_OR;
    else if (ch == "&" && pend_ch == "&") pair_type = T_AND;
  end

  assign is_end  = (op == OP_END) || (ch == CH_NUL);
  assign sop     = single_op(ch);
  assign run_ext = (run_len != '1) ? run_len + LB'(1) : run_len;

  // Next state and results for the current item
  always_comb begin
    mode_next      = mode;
    pend_ch_next   = pend_ch;
    prefix_next    = prefix;
    start_pos_next = start_pos;
    run_len_next   = run_len;
    byte_pos_next  = byte_pos;
    f_v = 1'b0; f_type = hold_type; f_start = start_pos; f_len = hold_len;
    s_v = 1'b0; s_type = T_EOF;     s_start = byte_pos;  s_len = '0;
    go_idle = 1'b0;

    if (is_end) begin
      // Flush, mark end of text, return to reset state
      f_v            = hold_v;
      s_v            = 1'b1;
      mode_next      = M_IDLE;
      pend_ch_next   = '0;
      for (int i = 0; i < KEYWORD_PREFIX; i++) prefix_next[i] = '0;
      start_pos_next = '0;
      run_len_next   = '0;
      byte_pos_next  = '0;
    end else begin
      byte_pos_next = byte_pos + PB'(1);
      unique case (mode)
        M_NUM: begin
          if (is_digit(ch)) begin
            run_len_next = run_ext;
          end else begin
            f_v     = 1'b1;
            go_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDERSCORE) begin
            for (int i = 0; i < KEYWORD_PREFIX; i++)
              if (run_len == LB'(i)) prefix_next[i] = ch;
            run_len_next = run_ext;
          end else begin
            f_v     = 1'b1;
            go_idle = 1'b1;
          end
        end
        M_PEND: begin
          f_v = 1'b1;
          if (pair_type != T_EOF) begin
            f_type    = pair_type;
            f_len     = LB'(2);
            mode_next = M_IDLE;
          end else if (hold_err) begin
            mode_next = M_ERROR;
          end else begin
            go_idle = 1'b1;
          end
        end
        M_IDLE:  go_idle = 1'b1;
        M_ERROR: go_idle = 1'b0;
        default: go_idle = 1'b0;
      endcase

      // Start a new token from this byte
      if (go_idle) begin
        mode_next = M_IDLE;
        if (is_space(ch)) begin
          mode_next = M_IDLE;
        end else if (is_digit(ch)) begin
          mode_next      = M_NUM;
          start_pos_next = byte_pos;
          run_len_next   = LB'(1);
        end else if (is_alpha(ch)) begin
          mode_next      = M_IDENT;
          start_pos_next = byte_pos;
          run_len_next   = LB'(1);
          for (int i = 1; i < KEYWORD_PREFIX; i++) prefix_next[i] = '0;
          prefix_next[0] = ch;
        end else if (is_pend_start(ch)) begin
          mode_next      = M_PEND;
          pend_ch_next   = ch;
          start_pos_next = byte_pos;
          run_len_next   = LB'(1);
        end else if (sop != T_EOF) begin
          s_v    = 1'b1;
          s_type = sop;
          s_len  = LB'(1);
        end else begin
          s_v       = 1'b1;
          s_type    = T_ERROR;
          s_len     = LB'(1);
          mode_next = M_ERROR;
        end
      end
    end
  end

  // Pack results in order; mark the final one
  always_comb begin
    sll_token_t ft, st;
    ft.token_type   = f_type;
    ft.token_start  = POS_W'(f_start);
    ft.token_length = LEN_W'(f_len);
    ft.last_of_item = !s_v;
    st.token_type   = s_type;
    st.token_start  = POS_W'(s_start);
    st.token_length = LEN_W'(s_len);
    st.last_of_item = 1'b1;
    push.valid0 = take && (f_v || s_v);
    push.valid1 = take && f_v && s_v;
    push.tok0   = f_v ? ft : st;
    push.tok1   = st;
  end

  // Update scanner state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      pend_ch  <= '0;
      for (int i = 0; i < KEYWORD_PREFIX; i++) prefix[i] <= '0;
      start_pos <= '0;
      run_len  <= '0;
      byte_pos <= '0;
    end else if (take) begin
      mode      <= mode_next;
      pend_ch   <= pend_ch_next;
      prefix    <= prefix_next;
      start_pos <= start_pos_next;
      run_len   <= run_len_next;
      byte_pos  <= byte_pos_next;
    end
  end

endmodule

FILE: rtl/sll_outq.sv
// Result queue of the lexer: takes up to two tokens a cycle, hands out one.
// Depends on sll_pkg.
module sll_outq (
  input  logic                clk,
  input  logic                rst,
  input  sll_pkg::sll_push_t  push,
  input  logic                pop,
  output logic                out_valid,
  output sll_pkg::sll_token_t head_tok,
  output logic                room
);
  import sll_pkg::*;

  localparam int PW = $clog2(OUTQ_DEPTH);
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  sll_token_t      entries [OUTQ_DEPTH];
  logic [PW-1:0]   head, tail;
  logic [CW-1:0]   count, count_next;
  logic [PW-1:0]   tail1;
  logic            do_pop;

  assign tail1     = tail + PW'(1);
  assign out_valid = (count != '0);
  assign head_tok  = entries[head];
  assign do_pop    = pop && out_valid;
  // Space for the two results one item may write
  assign room      = (count <= CW'(OUTQ_DEPTH - 2));

  always_comb begin
    count_next = count + CW'(push.valid0) + CW'(push.valid1) - CW'(do_pop);
  end

  // Write incoming tokens
  always_ff @(posedge clk) begin
    if (push.valid0) entries[tail] <= push.tok0;
    if (push.valid1) entries[tail1] <= push.tok1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_pop) head <= head + PW'(1);
      if (push.valid1)      tail <= tail + PW'(2);
      else if (push.valid0) tail <= tail1;
      count <= count_next;
    end
  end

endmodule

FILE: dv/tb_small_language_lexer_core.sv
// Self-checking testbench for small_language_lexer_core: random and directed source text.
// Uses sll_pkg, sll_in_if and sll_out_if from the RTL, and a token predictor of its own.
module tb_small_language_lexer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sll_pkg::*;

  // Scanner modes of the token predictor
  typedef enum logic [2:0] {
    LX_IDLE,
    LX_NUMBER,
    LX_WORD,
    LX_PENDING,
    LX_SKIP
  } lex_mode_e;

  // One source transaction waiting to be driven
  typedef struct {
    logic       op;
    logic [7:0] ch;
    bit         drain;
  } src_item_t;

  localparam int unsigned RUN_MAX = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sll_in_if  item_in ();
  sll_out_if token_out ();

  small_language_lexer_core dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_in),
    .token_out (token_out)
  );

  always #1 clk = ~clk;

  src_item_t  text_feed [$];
  sll_token_t tokens_due [$];

  // Predictor state
  lex_mode_e   lx_mode;
  logic [7:0]  lx_pend;
  logic [7:0]  lx_prefix [4];
  logic [15:0] lx_start;
  logic [15:0] lx_len;
  logic [15:0] lx_pos;
  sll_token_t  staged [2];
  int          n_staged;

  // Run bookkeeping
  bit feed_taken;
  int items_taken;
  int fail_count;
  int tokens_checked;
  int eof_tokens;
  int error_tokens;
  int keyword_tokens;
  int pair_tokens;
  int texts_built;

  string letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string near_words [16] = '{"exit", "int", "if", "else", "ex", "exi", "exits", "in",
                             "i", "iff", "el", "els", "elsee", "int0", "If", "EXIT"};
  string op_words [18] = '{"==", "=", "<=", "<", ">=", ">", "||", "&&", "+", "-",
                           "*", "/", "(", ")", "{", "}", "^", ";"};

  function automatic bit ch_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] lone_op(input logic [7:0] c);
    case (c)
      "+":     return T_PLUS;
      "-":     return T_MINUS;
      "*":     return T_STAR;
      "/":     return T_SLASH;
      "(":     return T_LPAREN;
      ")":     return T_RPAREN;
      "{":     return T_LBRACE;
      "}":     return T_RBRACE;
      "^":     return T_CARET;
      ";":     return T_SEMI;
      default: return T_EOF;
    endcase
  endfunction

  task automatic lex_clear();
    lx_mode  = LX_IDLE;
    lx_pend  = 8'h00;
    lx_start = 16'd0;
    lx_len   = 16'd0;
    lx_pos   = 16'd0;
    for (int i = 0; i < 4; i++) lx_prefix[i] = 8'h00;
  endtask

  task automatic stage_token(input logic [4:0] kind, input logic [15:0] start,
                             input logic [15:0] len);
    staged[n_staged] = '{kind, start, len, 1'b0};
    n_staged++;
  endtask

  // Emit the token held in the scanner; flag a lone bar or ampersand
  task automatic close_held(output bit bad);
    logic [4:0] kind;
    bad = 1'b0;
    case (lx_mode)
      LX_NUMBER: stage_token(T_INT, lx_start, lx_len);
      LX_WORD: begin
        kind = T_IDENT;
        if (lx_len == 16'd4 && {lx_prefix[0], lx_prefix[1], lx_prefix[2], lx_prefix[3]} == KW_EXIT)
          kind = T_EXIT;
        else if (lx_len == 16'd3 && {lx_prefix[0], lx_prefix[1], lx_prefix[2]} == KW_INT)
          kind = T_INT;
        else if (lx_len == 16'd2 && {lx_prefix[0], lx_prefix[1]} == KW_IF)
          kind = T_IF;
        else if (lx_len == 16'd4 &&
                 {lx_prefix[0], lx_prefix[1], lx_prefix[2], lx_prefix[3]} == KW_ELSE)
          kind = T_ELSE;
        stage_token(kind, lx_start, lx_len);
      end
      LX_PENDING: begin
        if (lx_pend == "|" || lx_pend == "&") begin
          stage_token(T_ERROR, lx_start, 16'd1);
          bad = 1'b1;
        end else begin
          kind = (lx_pend == "=") ? T_ASSIGN : (lx_pend == "<") ? T_LT : T_GT;
          stage_token(kind, lx_start, 16'd1);
        end
      end
      default: ;
    endcase
  endtask

  // Decide a byte that arrives with nothing held
  task automatic open_token(input logic [7:0] c, input logic [15:0] here);
    logic [4:0] kind;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
      // skip whitespace
    end else if (ch_digit(c)) begin
      lx_mode  = LX_NUMBER;
      lx_start = here;
      lx_len   = 16'd1;
    end else if (ch_letter(c)) begin
      lx_mode  = LX_WORD;
      lx_start = here;
      lx_len   = 16'd1;
      for (int i = 1; i < 4; i++) lx_prefix[i] = 8'h00;
      lx_prefix[0] = c;
    end else if (c == "=" || c == "<" || c == ">" || c == "|" || c == "&") begin
      lx_mode  = LX_PENDING;
      lx_pend  = c;
      lx_start = here;
      lx_len   = 16'd1;
    end else begin
      kind = lone_op(c);
      if (kind != T_EOF) begin
        stage_token(kind, here, 16'd1);
      end else begin
        stage_token(T_ERROR, here, 16'd1);
        lx_mode = LX_SKIP;
      end
    end
  endtask

  // Predict the tokens caused by one accepted transaction
  task automatic lex_step(input logic op, input logic [7:0] c);
    bit         bad;
    bit         fresh;
    logic [4:0] kind;
    logic [15:0] here;
    n_staged = 0;
    here = lx_pos;
    if (op == OP_END || c == CH_NUL) begin
      if (lx_mode != LX_SKIP) close_held(bad);
      stage_token(T_EOF, here, 16'd0);
      lex_clear();
    end else begin
      lx_pos = here + 16'd1;
      fresh = 1'b0;
      case (lx_mode)
        LX_IDLE: fresh = 1'b1;
        LX_NUMBER: begin
          if (ch_digit(c)) begin
            if (lx_len < RUN_MAX) lx_len++;
          end else begin
            close_held(bad);
            lx_mode = LX_IDLE;
            fresh = 1'b1;
          end
        end
        LX_WORD: begin
          if (ch_letter(c) || ch_digit(c) || c == CH_UNDERSCORE) begin
            if (lx_len < 16'd4) lx_prefix[lx_len[1:0]] = c;
            if (lx_len < RUN_MAX) lx_len++;
          end else begin
            close_held(bad);
            lx_mode = LX_IDLE;
            fresh = 1'b1;
          end
        end
        LX_PENDING: begin
          kind = T_EOF;
          if (c == "=" && lx_pend == "=") kind = T_EE;
          else if (c == "=" && lx_pend == "<") kind = T_LTE;
          else if (c == "=" && lx_pend == ">") kind = T_GTE;
          else if (c == "|" && lx_pend == "|") kind = T_OR;
          else if (c == "&" && lx_pend == "&") kind = T_AND;
          if (kind != T_EOF) begin
            stage_token(kind, lx_start, 16'd2);
            lx_mode = LX_IDLE;
          end else begin
            // a lone bar or ampersand swallows the byte after it
            close_held(bad);
            lx_mode = bad ? LX_SKIP : LX_IDLE;
            fresh = !bad;
          end
        end
        default: ;
      endcase
      if (fresh) open_token(c, here);
    end
    if (n_staged > 0) staged[n_staged-1].last_of_item = 1'b1;
    for (int i = 0; i < n_staged; i++) tokens_due.push_back(staged[i]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token();
    sll_token_t want;
    if (tokens_due.size() == 0) begin
      $display("%0t: unexpected token, expected none, actual type %0d start %0d length %0d",
               $time, token_out.token_type, token_out.token_start, token_out.token_length);
      fail_count++;
    end else begin
      want = tokens_due.pop_front();
      check_field("token_type", 32'(want.token_type), 32'(token_out.token_type));
      check_field("token_start", 32'(want.token_start), 32'(token_out.token_start));
      check_field("token_length", 32'(want.token_length), 32'(token_out.token_length));
      check_field("last_of_item", 32'(want.last_of_item), 32'(token_out.last_of_item));
      tokens_checked++;
      case (want.token_type)
        T_EOF:                   eof_tokens++;
        T_ERROR:                 error_tokens++;
        T_EXIT, T_IF, T_ELSE:    keyword_tokens++;
        T_EE, T_LTE, T_GTE, T_OR, T_AND: pair_tokens++;
        default: ;
      endcase
    end
  endtask

  // Monitor: predict on accepted input, compare accepted output
  always @(posedge clk) begin
    if (rst) begin
      lex_clear();
      tokens_due.delete();
      feed_taken <= 1'b0;
    end else begin
      feed_taken <= item_in.valid && item_in.ready;
      if (item_in.valid && item_in.ready) begin
        lex_step(item_in.op, item_in.ch);
        items_taken++;
      end
      if (token_out.valid && token_out.ready) check_token();
    end
  end

  // Driver: offer queued transactions in bursts, hold until accepted
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    bit offer;
    if (rst) begin
      item_in.valid <= 1'b0;
    end else begin
      if (feed_taken) text_feed.delete(0);
      offer = item_in.valid && !feed_taken;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_feed.size() > 0 &&
                     !(text_feed[0].drain && tokens_due.size() > 0)) begin
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
          end
        end
      end
      item_in.valid <= offer;
      if (offer) begin
        item_in.op <= text_feed[0].op;
        item_in.ch <= text_feed[0].ch;
      end
    end
  end

  // Receiver: stall in phases of random density, with long hold-offs now and then
  int hold_left = 0;
  int hold_mark = 150;
  int phase_left = 0;
  int ready_pct = 100;

  always @(negedge clk) begin
    bit take;
    if (rst) begin
      token_out.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && items_taken >= hold_mark) begin
        hold_left = 120;
        hold_mark += 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(20, 200);
          case ($urandom_range(0, 2))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            default: ready_pct = 30;
          endcase
        end
        phase_left--;
        take = $urandom_range(0, 99) < ready_pct;
      end
      token_out.ready <= take;
    end
  end

  // Stimulus builders
  task automatic add_byte(input logic [7:0] c);
    text_feed.push_back('{OP_CHAR, c, 1'b0});
  endtask

  task automatic add_end(input logic [7:0] c);
    text_feed.push_back('{OP_END, c, 1'b0});
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // Build one text of random lexemes, mostly well formed, with some noise
  task automatic add_random_text(inout int added);
    int first;
    int pick;
    first = text_feed.size();
    repeat ($urandom_range(2, 12)) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 42) begin
        if ($urandom_range(0, 1) == 1) begin
          add_string(near_words[$urandom_range(0, 15)]);
        end else begin
          add_byte(letters[$urandom_range(0, letters.len() - 1)]);
          repeat ($urandom_range(0, 7))
            add_byte(word_chars[$urandom_range(0, word_chars.len() - 1)]);
        end
      end else if (pick < 70) begin
        add_string(op_words[$urandom_range(0, 17)]);
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0:       add_byte(CH_SPACE);
          1:       add_byte(CH_TAB);
          default: add_byte(CH_NEWLINE);
        endcase
      end else if (pick < 96) begin
        add_byte(8'($urandom_range(1, 255)));
      end else begin
        add_byte($urandom_range(0, 1) == 1 ? "|" : "&");
      end
    end
    if ($urandom_range(0, 9) < 6) add_end(8'($urandom_range(0, 255)));
    else add_byte(CH_NUL);
    added += text_feed.size() - first;
    texts_built++;
    // pause the sender until every token is out
    if (texts_built % 50 == 25) text_feed[first].drain = 1'b1;
  endtask

  initial begin
    int added;
    item_in.valid   = 1'b0;
    item_in.op      = OP_CHAR;
    item_in.ch      = 8'h00;
    token_out.ready = 1'b0;
    added = 0;

    // directed: keywords and pairs, lone bar, lone ampersand at end, unknown bytes
    add_string("else{x<=42}");
    add_byte(CH_NUL);
    add_string("a|b");
    add_end(8'h00);
    add_byte("&");
    add_end(8'h5A);
    add_byte(8'hFF);
    add_byte("x");
    add_end(8'hFF);
    add_byte(CH_UNDERSCORE);
    add_end(8'h00);

    while (added < 1270) add_random_text(added);

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (text_feed.size() != 0 || item_in.valid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d transactions in %0d texts, %0d tokens checked", items_taken,
             eof_tokens, tokens_checked);
    $display("  incl. %0d keywords, %0d two-char operators, %0d error tokens, %0d mismatches",
             keyword_tokens, pair_tokens, error_tokens, fail_count);
    if (tokens_due.size() != 0)
      $display("%0t: %0d expected tokens never arrived", $time, tokens_due.size());
    if (fail_count == 0 && tokens_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400_000;
    $display("%0t: timeout with %0d tokens outstanding", $time, tokens_due.size());
    $display("status: fail");
    $finish;
  end

endmodule
